[sv/kf2_pkg.sv]
// ----------------------------------------------------------------------------
// kf2_pkg
// Shared constants of the two-state Kalman filter: default number format and
// configuration register indexes.
// ----------------------------------------------------------------------------
package kf2_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 64;

  localparam logic [CFG_INDEX_BITS-1:0] REG_A_ROW0 = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_A_ROW1 = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_H_ROW0 = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_H_ROW1 = 4'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_Q_ROW0 = 4'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_Q_ROW1 = 4'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_R_ROW0 = 4'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_R_ROW1 = 4'd7;

endpackage

[sv/kf2_div.sv]
// ----------------------------------------------------------------------------
// kf2_div
// Radix-2 restoring divider: round-to-nearest fixed-point quotient
// (+/-num * 2^FRAC_BITS) / den, saturated to the word range.
// ----------------------------------------------------------------------------
module kf2_div #(
  parameter int WORD_WIDTH = kf2_pkg::WORD_WIDTH,
  parameter int FRAC_BITS  = kf2_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [WORD_WIDTH-1:0] num,
  input  logic                         num_neg,
  input  logic signed [WORD_WIDTH-1:0] den,
  output logic                         done,
  output logic signed [WORD_WIDTH-1:0] quot
);

  localparam int W  = WORD_WIDTH;
  localparam int NB = W + FRAC_BITS + 2;
  localparam int CW = $clog2(NB + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(NB - 1);
  localparam logic [NB-1:0] QMAX_U = NB'({1'b0, {(W-1){1'b1}}});
  localparam logic [NB-1:0] QMIN_U = QMAX_U + NB'(1);
  localparam logic signed [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]    un;
  logic [W-1:0]    ud;
  logic [NB-1:0]   n_full;
  logic [W+1:0]    sh;
  logic            ge;
  logic [W+1:0]    rem_r;
  logic [NB-1:0]   quo_r;
  logic [W:0]      den_r;
  logic            neg_r;
  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;

  assign un     = num[W-1] ? W'(-num) : W'(num);
  assign ud     = den[W-1] ? W'(-den) : W'(den);
  assign n_full = {un, {FRAC_BITS{1'b0}}, 1'b0} + NB'(ud);
  assign sh     = {rem_r[W:0], quo_r[NB-1]};
  assign ge     = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= n_full;
        den_r  <= {ud, 1'b0};
        neg_r  <= ((num != '0) && (num_neg ? !num[W-1] : num[W-1])) ^ den[W-1];
      end else if (busy_r) begin
        rem_r <= ge ? sh - {1'b0, den_r} : sh;
        quo_r <= {quo_r[NB-2:0], ge};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (!neg_r) begin
      quot = (quo_r > QMAX_U) ? QMAX : quo_r[W-1:0];
    end else begin
      quot = (quo_r > QMIN_U) ? QMIN : W'(-quo_r[W-1:0]);
    end
  end

  assign done = done_r;

endmodule

[sv/kalman_filter_two_state.sv]
// ----------------------------------------------------------------------------
// kalman_filter_two_state
// Two-state fixed-point Kalman filter on one shared multiply-add unit plus
// an iterative divider for the inverse of the innovation covariance.
// ----------------------------------------------------------------------------
// Numbers are Q16.16 at the default parameters. Singular items end after the
// determinant and skip the divider. One item at a time: the sequencer and the
// single multiply-add unit set the rate.
// Synchronous reset loads identity A, H, R, zero Q and clears estimate and
// covariance.
// ----------------------------------------------------------------------------
module kalman_filter_two_state #(
  parameter int WORD_WIDTH = kf2_pkg::WORD_WIDTH,
  parameter int FRAC_BITS  = kf2_pkg::FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [31:0]                     in_meas_position,
  input  logic signed [31:0]                     in_meas_velocity,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [31:0]                     out_est_position,
  output logic signed [31:0]                     out_est_velocity,
  output logic                                   out_singular,
  input  logic                                   cfg_we,
  input  logic [kf2_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [kf2_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int W = WORD_WIDTH;
  localparam logic signed [W-1:0]   QMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]   QMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]   ONE  = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [2*W:0]   HALF = {{(2*W){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_XM   = 15'b000000000000010,
    ST_AP   = 15'b000000000000100,
    ST_PAT  = 15'b000000000001000,
    ST_HP   = 15'b000000000010000,
    ST_SHT  = 15'b000000000100000,
    ST_DET  = 15'b000000001000000,
    ST_DIV  = 15'b000000010000000,
    ST_PHT  = 15'b000000100000000,
    ST_KSI  = 15'b000001000000000,
    ST_INN  = 15'b000010000000000,
    ST_EST  = 15'b000100000000000,
    ST_KH   = 15'b001000000000000,
    ST_PU   = 15'b010000000000000,
    ST_DONE = 15'b100000000000000
  } state_t;

  function automatic logic signed [W-1:0] satw(input logic signed [2*W:0] v);
    if (v > (2*W+1)'(QMAX)) begin
      return QMAX;
    end else if (v < (2*W+1)'(QMIN)) begin
      return QMIN;
    end else begin
      return v[W-1:0];
    end
  endfunction

  function automatic logic signed [W-1:0] sat32(input logic signed [31:0] v);
    return satw((2*W+1)'(v));
  endfunction

  state_t state_r, state_nxt;
  logic [1:0] e_r;
  logic [1:0] k_r;
  logic       div_wait_r;
  logic       singular_r;
  logic       out_valid_r;
  logic       out_sing_r;

  logic signed [W-1:0] a_r [4];
  logic signed [W-1:0] h_r [4];
  logic signed [W-1:0] q_r [4];
  logic signed [W-1:0] r_r [4];
  logic signed [W-1:0] x_r [2];
  logic signed [W-1:0] p_r [4];
  logic signed [W-1:0] z_r [2];
  logic signed [W-1:0] xm_r [2];
  logic signed [W-1:0] pm_r [4];
  logic signed [W-1:0] s_r [4];
  logic signed [W-1:0] si_r [4];
  logic signed [W-1:0] t_r [4];
  logic signed [W-1:0] k_mat_r [4];
  logic signed [W-1:0] inn_r [2];
  logic signed [W-1:0] tmp_r;
  logic signed [W-1:0] det_r;
  logic signed [W-1:0] est_pos_r;
  logic signed [W-1:0] est_vel_r;

  logic                i, j, c;
  logic [1:0]          last_k;
  logic [1:0]          last_e;
  logic                op_st;
  logic signed [W-1:0] mx, my, mz;
  logic                mneg;
  logic signed [2*W-1:0] prod;
  logic signed [2*W:0]   rnd;
  logic signed [W-1:0]   mval;
  logic signed [2*W:0]   sum;
  logic signed [W-1:0]   res;
  logic                  in_accept;
  logic                  out_free;
  logic                  div_start;
  logic                  div_done;
  logic signed [W-1:0]   div_num;
  logic                  div_num_neg;
  logic signed [W-1:0]   div_quot;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign op_st     = !((state_r == ST_IDLE) || (state_r == ST_DIV) || (state_r == ST_DONE));

  assign c = k_r[0];

  always_comb begin
    unique case (state_r)
      ST_XM, ST_INN, ST_EST: begin
        i      = e_r[0];
        j      = 1'b0;
        last_e = 2'd1;
      end
      ST_DET: begin
        i      = 1'b0;
        j      = 1'b0;
        last_e = 2'd0;
      end
      default: begin
        i      = e_r[1];
        j      = e_r[0];
        last_e = 2'd3;
      end
    endcase
    unique case (state_r)
      ST_PAT, ST_SHT, ST_INN, ST_EST, ST_KH: last_k = 2'd2;
      default:                               last_k = 2'd1;
    endcase
  end

  always_comb begin
    mx   = '0;
    my   = '0;
    mz   = '0;
    mneg = 1'b0;
    if (k_r == 2'd2) begin
      my = ONE;
      unique case (state_r)
        ST_PAT: begin
          mx = tmp_r;
          mz = q_r[e_r];
        end
        ST_SHT: begin
          mx = tmp_r;
          mz = r_r[e_r];
        end
        ST_INN: begin
          mx   = z_r[i];
          mz   = tmp_r;
          mneg = 1'b1;
        end
        ST_EST: begin
          mx = xm_r[i];
          mz = tmp_r;
        end
        ST_KH: begin
          mx   = (i == j) ? ONE : '0;
          mz   = tmp_r;
          mneg = 1'b1;
        end
        default: begin
          mx = '0;
        end
      endcase
    end else begin
      mz = (k_r == 2'd1) ? tmp_r : '0;
      unique case (state_r)
        ST_XM: begin
          mx = a_r[{i, c}];
          my = x_r[c];
        end
        ST_AP: begin
          mx = a_r[{i, c}];
          my = p_r[{c, j}];
        end
        ST_PAT: begin
          mx = t_r[{i, c}];
          my = a_r[{j, c}];
        end
        ST_HP: begin
          mx = h_r[{i, c}];
          my = pm_r[{c, j}];
        end
        ST_SHT: begin
          mx = k_mat_r[{i, c}];
          my = h_r[{j, c}];
        end
        ST_DET: begin
          mx   = c ? s_r[0] : s_r[1];
          my   = c ? s_r[3] : s_r[2];
          mneg = c;
        end
        ST_PHT: begin
          mx = pm_r[{i, c}];
          my = h_r[{j, c}];
        end
        ST_KSI: begin
          mx = t_r[{i, c}];
          my = si_r[{c, j}];
        end
        ST_INN: begin
          mx = h_r[{i, c}];
          my = xm_r[c];
        end
        ST_EST: begin
          mx = k_mat_r[{i, c}];
          my = inn_r[c];
        end
        ST_KH: begin
          mx = k_mat_r[{i, c}];
          my = h_r[{c, j}];
        end
        ST_PU: begin
          mx = t_r[{i, c}];
          my = pm_r[{c, j}];
        end
        default: begin
          mx = '0;
        end
      endcase
    end
  end

  assign prod = mx * my;
  assign rnd  = (2*W+1)'(prod) + HALF;
  assign mval = satw(rnd >>> FRAC_BITS);
  assign sum  = mneg ? (2*W+1)'(mval) - (2*W+1)'(mz) : (2*W+1)'(mval) + (2*W+1)'(mz);
  assign res  = satw(sum);

  always_comb begin
    unique case (e_r)
      2'd0: begin
        div_num     = s_r[3];
        div_num_neg = 1'b0;
      end
      2'd1: begin
        div_num     = s_r[1];
        div_num_neg = 1'b1;
      end
      2'd2: begin
        div_num     = s_r[2];
        div_num_neg = 1'b1;
      end
      default: begin
        div_num     = s_r[0];
        div_num_neg = 1'b0;
      end
    endcase
  end

  assign div_start = (state_r == ST_DIV) && !div_wait_r;

  kf2_div #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num     (div_num),
    .num_neg (div_num_neg),
    .den     (det_r),
    .done    (div_done),
    .quot    (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_XM;
      ST_DIV:  if (div_wait_r && div_done && e_r == 2'd3) state_nxt = ST_PHT;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: begin
        if (k_r == last_k && e_r == last_e) begin
          unique case (state_r)
            ST_XM:   state_nxt = ST_AP;
            ST_AP:   state_nxt = ST_PAT;
            ST_PAT:  state_nxt = ST_HP;
            ST_HP:   state_nxt = ST_SHT;
            ST_SHT:  state_nxt = ST_DET;
            ST_DET:  state_nxt = (res == '0) ? ST_DONE : ST_DIV;
            ST_PHT:  state_nxt = ST_KSI;
            ST_KSI:  state_nxt = ST_INN;
            ST_INN:  state_nxt = ST_EST;
            ST_EST:  state_nxt = ST_KH;
            ST_KH:   state_nxt = ST_PU;
            ST_PU:   state_nxt = ST_DONE;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      e_r         <= '0;
      k_r         <= '0;
      div_wait_r  <= 1'b0;
      singular_r  <= 1'b0;
      out_valid_r <= 1'b0;
      a_r[0] <= ONE;
      a_r[1] <= '0;
      a_r[2] <= '0;
      a_r[3] <= ONE;
      h_r[0] <= ONE;
      h_r[1] <= '0;
      h_r[2] <= '0;
      h_r[3] <= ONE;
      r_r[0] <= ONE;
      r_r[1] <= '0;
      r_r[2] <= '0;
      r_r[3] <= ONE;
      for (int n = 0; n < 4; n++) begin
        q_r[n] <= '0;
        p_r[n] <= '0;
      end
      x_r[0] <= '0;
      x_r[1] <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          kf2_pkg::REG_A_ROW0: begin
            a_r[0] <= sat32(cfg_data[63:32]);
            a_r[1] <= sat32(cfg_data[31:0]);
          end
          kf2_pkg::REG_A_ROW1: begin
            a_r[2] <= sat32(cfg_data[63:32]);
            a_r[3] <= sat32(cfg_data[31:0]);
          end
          kf2_pkg::REG_H_ROW0: begin
            h_r[0] <= sat32(cfg_data[63:32]);
            h_r[1] <= sat32(cfg_data[31:0]);
          end
          kf2_pkg::REG_H_ROW1: begin
            h_r[2] <= sat32(cfg_data[63:32]);
            h_r[3] <= sat32(cfg_data[31:0]);
          end
          kf2_pkg::REG_Q_ROW0: begin
            q_r[0] <= sat32(cfg_data[63:32]);
            q_r[1] <= sat32(cfg_data[31:0]);
          end
          kf2_pkg::REG_Q_ROW1: begin
            q_r[2] <= sat32(cfg_data[63:32]);
            q_r[3] <= sat32(cfg_data[31:0]);
          end
          kf2_pkg::REG_R_ROW0: begin
            r_r[0] <= sat32(cfg_data[63:32]);
            r_r[1] <= sat32(cfg_data[31:0]);
          end
          kf2_pkg::REG_R_ROW1: begin
            r_r[2] <= sat32(cfg_data[63:32]);
            r_r[3] <= sat32(cfg_data[31:0]);
          end
          default: begin
          end
        endcase
      end

      if (in_accept) begin
        z_r[0]     <= sat32(in_meas_position);
        z_r[1]     <= sat32(in_meas_velocity);
        singular_r <= 1'b0;
        e_r        <= '0;
        k_r        <= '0;
      end

      if (op_st) begin
        if (k_r == last_k) begin
          k_r <= '0;
          e_r <= (e_r == last_e) ? 2'd0 : e_r + 2'd1;
          unique case (state_r)
            ST_XM:  xm_r[i]      <= res;
            ST_AP:  t_r[e_r]     <= res;
            ST_PAT: pm_r[e_r]    <= res;
            ST_HP:  k_mat_r[e_r] <= res;
            ST_SHT: s_r[e_r]     <= res;
            ST_DET: begin
              det_r <= res;
              if (res == '0) singular_r <= 1'b1;
            end
            ST_PHT: t_r[e_r]     <= res;
            ST_KSI: k_mat_r[e_r] <= res;
            ST_INN: inn_r[i]     <= res;
            ST_EST: x_r[i]       <= res;
            ST_KH:  t_r[e_r]     <= res;
            ST_PU:  p_r[e_r]     <= res;
            default: begin
            end
          endcase
        end else begin
          k_r   <= k_r + 2'd1;
          tmp_r <= res;
        end
      end

      if (state_r == ST_DIV) begin
        if (!div_wait_r) begin
          div_wait_r <= 1'b1;
        end else if (div_done) begin
          si_r[e_r]  <= div_quot;
          div_wait_r <= 1'b0;
          e_r        <= e_r + 2'd1;
        end
      end

      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        est_pos_r   <= x_r[0];
        est_vel_r   <= x_r[1];
        out_sing_r  <= singular_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_est_position = 32'(est_pos_r);
  assign out_est_velocity = 32'(est_vel_r);
  assign out_singular     = out_sing_r;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-state fixed-point Kalman filter. A clocked
// driver sends measurement items from a queue in random bursts. A monitor
// compares every estimate with a bit-exact predictor of the filter. The
// predictor sees the same register writes and keeps its own state. The run
// steps through tracking, wild, saturating and singular settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QMAX = (64'sd1 <<< (kf2_pkg::WORD_WIDTH - 1)) - 1;
  localparam longint QMIN = -QMAX - 1;
  localparam longint QONE = 64'sd1 <<< kf2_pkg::FRAC_BITS;
  localparam logic [kf2_pkg::CFG_INDEX_BITS-1:0] REG_BAD_LO = 4'd8;
  localparam logic [kf2_pkg::CFG_INDEX_BITS-1:0] REG_BAD_HI = 4'd15;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 2500;

  typedef longint mat_t [4];
  typedef longint vec_t [2];
  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } meas_t;
  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               sing;
  } est_t;
  typedef enum int {KIND_TRACK, KIND_WILD, KIND_MAX, KIND_MIN} cfg_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_meas_position = '0;
  logic signed [31:0] in_meas_velocity = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [31:0] out_est_position;
  logic signed [31:0] out_est_velocity;
  logic out_singular;
  logic cfg_we = 1'b0;
  logic [kf2_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [kf2_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  kalman_filter_two_state dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  meas_t  pending_meas[$];
  est_t   expected_est[$];
  logic [63:0] kf_regs [8];
  longint kf_est [2];
  longint kf_cov [4];
  int mismatches = 0;
  int results_seen = 0;
  int singular_seen = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  logic took = 1'b0;

  function automatic longint sat(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (kf2_pkg::FRAC_BITS - 1));
    return sat(p >>> kf2_pkg::FRAC_BITS);
  endfunction

  function automatic longint qadd(longint a, longint b);
    return sat(a + b);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return sat(a - b);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    longint unsigned un, ud, q;
    longint r;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = (2 * un + ud) / (2 * ud);
    if (q > QMAX + 1) q = QMAX + 1;
    r = q;
    if ((n < 0) != (d < 0)) r = -r;
    return sat(r);
  endfunction

  function automatic mat_t row_pair(logic [63:0] r0, logic [63:0] r1);
    mat_t m;
    m[0] = sat(longint'($signed(r0[63:32])));
    m[1] = sat(longint'($signed(r0[31:0])));
    m[2] = sat(longint'($signed(r1[63:32])));
    m[3] = sat(longint'($signed(r1[31:0])));
    return m;
  endfunction

  function automatic mat_t mmul(mat_t a, mat_t b);
    mat_t t;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        t[i*2+j] = qadd(qmul(a[i*2], b[j]), qmul(a[i*2+1], b[2+j]));
    return t;
  endfunction

  function automatic mat_t madd(mat_t a, mat_t b);
    mat_t t;
    for (int i = 0; i < 4; i++) t[i] = qadd(a[i], b[i]);
    return t;
  endfunction

  function automatic mat_t mtrans(mat_t a);
    mat_t t;
    t[0] = a[0]; t[1] = a[2]; t[2] = a[1]; t[3] = a[3];
    return t;
  endfunction

  function automatic vec_t mvec(mat_t m, vec_t v);
    vec_t r;
    r[0] = qadd(qmul(m[0], v[0]), qmul(m[1], v[1]));
    r[1] = qadd(qmul(m[2], v[0]), qmul(m[3], v[1]));
    return r;
  endfunction

  function automatic est_t kalman_update(meas_t z_in);
    mat_t a, h, ht, q, r, pm, s, si, k, t;
    vec_t x, z, xm, hx, inn, kv;
    longint det;
    est_t res;
    a = row_pair(kf_regs[kf2_pkg::REG_A_ROW0], kf_regs[kf2_pkg::REG_A_ROW1]);
    h = row_pair(kf_regs[kf2_pkg::REG_H_ROW0], kf_regs[kf2_pkg::REG_H_ROW1]);
    q = row_pair(kf_regs[kf2_pkg::REG_Q_ROW0], kf_regs[kf2_pkg::REG_Q_ROW1]);
    r = row_pair(kf_regs[kf2_pkg::REG_R_ROW0], kf_regs[kf2_pkg::REG_R_ROW1]);
    ht = mtrans(h);
    z[0] = sat(longint'(z_in.pos));
    z[1] = sat(longint'(z_in.vel));
    x[0] = kf_est[0];
    x[1] = kf_est[1];
    xm = mvec(a, x);
    pm = madd(mmul(mmul(a, kf_cov), mtrans(a)), q);
    s = madd(mmul(mmul(h, pm), ht), r);
    det = qsub(qmul(s[0], s[3]), qmul(s[1], s[2]));
    res.sing = (det == 0);
    if (det != 0) begin
      si[0] = qdiv(s[3] * QONE, det);
      si[1] = qdiv(-s[1] * QONE, det);
      si[2] = qdiv(-s[2] * QONE, det);
      si[3] = qdiv(s[0] * QONE, det);
      k = mmul(mmul(pm, ht), si);
      hx = mvec(h, xm);
      inn[0] = qsub(z[0], hx[0]);
      inn[1] = qsub(z[1], hx[1]);
      kv = mvec(k, inn);
      kf_est[0] = qadd(xm[0], kv[0]);
      kf_est[1] = qadd(xm[1], kv[1]);
      t = mmul(k, h);
      for (int i = 0; i < 4; i++) t[i] = qsub((i == 0 || i == 3) ? QONE : 0, t[i]);
      kf_cov = mmul(t, pm);
    end
    res.pos = kf_est[0][31:0];
    res.vel = kf_est[1][31:0];
    return res;
  endfunction

  // driver: bursts of items with random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || took)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_meas.size() > 0) begin
        meas_t m;
        m = pending_meas.pop_front();
        in_meas_position <= m.pos;
        in_meas_velocity <= m.vel;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern that changes mode, plus one long hold-off
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  logic hold_used = 1'b0;
  always @(negedge clk) begin
    if (!hold_used && results_seen == 300) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(50, 3000);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= ($urandom_range(0, 99) < 97);
      endcase
    end
  end

  // accept, predict, compare
  always @(posedge clk) begin
    logic in_fire, out_fire;
    est_t exp_est;
    in_fire = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    took <= in_fire;
    if (in_fire)
      expected_est.push_back(kalman_update('{in_meas_position, in_meas_velocity}));
    if (out_fire) begin
      results_seen++;
      if (out_singular) singular_seen++;
      if (expected_est.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result pos=%0d vel=%0d sing=%0b",
                   out_est_position, out_est_velocity, out_singular);
      end else begin
        exp_est = expected_est.pop_front();
        if (out_est_position !== exp_est.pos || out_est_velocity !== exp_est.vel ||
            out_singular !== exp_est.sing) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected pos=%0d vel=%0d sing=%0b, got pos=%0d vel=%0d sing=%0b",
                     results_seen, exp_est.pos, exp_est.vel, exp_est.sing,
                     out_est_position, out_est_velocity, out_singular);
        end
      end
    end
    if (in_fire || out_fire || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [kf2_pkg::CFG_INDEX_BITS-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx <= kf2_pkg::REG_R_ROW1) kf_regs[idx] = val;
    cfg_writes++;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_meas.size() != 0 || in_valid || expected_est.size() != 0);
  endtask

  function automatic logic [31:0] diag_half(int lo, int hi);
    return $urandom_range(lo, hi);
  endfunction

  task automatic load_setting(cfg_kind_t kind);
    logic [63:0] v [8];
    logic [31:0] offd;
    case (kind)
      KIND_TRACK: begin
        offd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : 0;
        v[kf2_pkg::REG_A_ROW0] = {32'(QONE), diag_half(0, 16384)};
        v[kf2_pkg::REG_A_ROW1] = {32'd0, 32'(QONE)};
        v[kf2_pkg::REG_H_ROW0] = {diag_half(49152, 81920), offd};
        v[kf2_pkg::REG_H_ROW1] = {offd, diag_half(49152, 81920)};
        v[kf2_pkg::REG_Q_ROW0] = {diag_half(0, 4096), 32'd0};
        v[kf2_pkg::REG_Q_ROW1] = {32'd0, diag_half(0, 4096)};
        v[kf2_pkg::REG_R_ROW0] = {diag_half(1024, 262144), 32'd0};
        v[kf2_pkg::REG_R_ROW1] = {32'd0, diag_half(1024, 262144)};
      end
      KIND_WILD: for (int i = 0; i < 8; i++) v[i] = {$urandom, $urandom};
      KIND_MAX:  for (int i = 0; i < 8; i++) v[i] = {2{32'(QMAX)}};
      default:   for (int i = 0; i < 8; i++) v[i] = {2{32'(QMIN)}};
    endcase
    for (int i = 0; i < 8; i++) write_reg(i[kf2_pkg::CFG_INDEX_BITS-1:0], v[i]);
    end_writes();
  endtask

  function automatic meas_t random_meas();
    meas_t m;
    if ($urandom_range(0, 4) == 0) begin
      m.pos = $urandom;
      m.vel = $urandom;
    end else begin
      m.pos = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      m.vel = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    end
    return m;
  endfunction

  cfg_kind_t phase_kind [10] = '{KIND_TRACK, KIND_WILD, KIND_TRACK, KIND_MAX, KIND_TRACK,
                                 KIND_MIN, KIND_TRACK, KIND_WILD, KIND_TRACK, KIND_TRACK};

  initial begin
    kf_regs[kf2_pkg::REG_A_ROW0] = 64'(QONE) << 32;
    kf_regs[kf2_pkg::REG_A_ROW1] = 64'(QONE);
    kf_regs[kf2_pkg::REG_H_ROW0] = 64'(QONE) << 32;
    kf_regs[kf2_pkg::REG_H_ROW1] = 64'(QONE);
    kf_regs[kf2_pkg::REG_Q_ROW0] = '0;
    kf_regs[kf2_pkg::REG_Q_ROW1] = '0;
    kf_regs[kf2_pkg::REG_R_ROW0] = 64'(QONE) << 32;
    kf_regs[kf2_pkg::REG_R_ROW1] = 64'(QONE);
    kf_est = '{0, 0};
    kf_cov = '{0, 0, 0, 0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: field extremes and alternating bits
    pending_meas.push_back('{32'sd0, 32'sd0});
    pending_meas.push_back('{32'(QMAX), 32'(QMIN)});
    pending_meas.push_back('{32'(QMIN), 32'(QMAX)});
    pending_meas.push_back('{32'(QMAX), 32'(QMAX)});
    pending_meas.push_back('{32'(QMIN), 32'(QMIN)});
    pending_meas.push_back('{-32'sd1, 32'sd1});
    pending_meas.push_back('{32'h5555_5555, 32'hAAAA_AAAA});
    pending_meas.push_back('{32'hAAAA_AAAA, 32'h5555_5555});
    for (int i = 0; i < 8; i++) pending_meas.push_back(random_meas());
    wait_drained();

    // zero measurement noise with zero covariance: singular innovation
    write_reg(kf2_pkg::REG_R_ROW0, '0);
    write_reg(kf2_pkg::REG_R_ROW1, '0);
    end_writes();
    for (int i = 0; i < 4; i++) pending_meas.push_back(random_meas());
    wait_drained();

    // writes to unused indexes must be dropped
    write_reg(REG_BAD_LO, {2{32'(QONE)}});
    write_reg(REG_BAD_HI, '1);
    write_reg(kf2_pkg::REG_R_ROW0, 64'(QONE) << 32);
    write_reg(kf2_pkg::REG_R_ROW1, 64'(QONE));
    end_writes();
    for (int i = 0; i < 3; i++) pending_meas.push_back(random_meas());
    wait_drained();

    foreach (phase_kind[p]) begin
      load_setting(phase_kind[p]);
      repeat ((phase_kind[p] == KIND_TRACK) ? 240 : 60) pending_meas.push_back(random_meas());
      wait_drained();
    end

    repeat (400) @(posedge clk);
    $display("covered %0d estimates (%0d singular) over %0d register writes",
             results_seen, singular_seen, cfg_writes);
    $display("tracking, random, saturated and singular settings; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_est.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
